// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the back end of the gaussian row normalizer
// expects signals named clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge out of reset
`define GN_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a result in the next
`define GN_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

// ----- hw/rtl/gnorm_pkg.sv -----
// shared types, constants and tables of the gaussian row normalizer
// no dependencies
`default_nettype none
package gnorm_pkg;

  localparam int unsigned MAX_NEIGHBORS_DEF = 16;
  localparam int unsigned INDEX_BITS        = 24;
  localparam int unsigned ROW_W             = 24;
  localparam int unsigned NBR_W             = 26;
  localparam int unsigned DIST_W            = 32;
  localparam int unsigned COL_W             = 24;
  localparam int unsigned WGT_W             = 32;
  localparam int unsigned EDGE_W            = 32;
  localparam int unsigned TOT_W             = 48;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned DIV_W             = 57;

  // fixed point constants of the exp approximation
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] X_CAP     = 32'h2000_0000;
  localparam logic [3:0]  TAYLOR_K  = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXP_COEF     = 3'd0,
    CFG_RADIUS_LIMIT = 3'd1,
    CFG_RADIUS_EN    = 3'd2,
    CFG_NORMALIZE    = 3'd3,
    CFG_SELF_WEIGHT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_DROP,
    KIND_SELF,
    KIND_GAUSS
  } cand_kind_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] distance;
    cand_kind_t        kind;
    logic              row_end;
  } cand_t;

  typedef struct packed {
    logic [31:0] exp_coef;
    logic [31:0] radius_limit;
    logic        radius_en;
    logic        normalize;
    logic [31:0] self_link_w;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_D2, ST_HI, ST_LO, ST_X, ST_XC, ST_Y, ST_T,
    ST_MUL, ST_QUO, ST_FIX, ST_ROUND, ST_STORE, ST_ENDCHK,
    ST_LOAD, ST_DIV, ST_SAT, ST_EMIT
  } back_state_t;

  // floor(2^32 / k), one short for k of one; the estimate is fixed up by one compare
  function automatic logic [31:0] recip_k(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gnorm_channels.sv -----
// valid/ready channel interfaces: candidate input, weight output, config writes
// depends on gnorm_pkg
`default_nettype none
interface gnorm_in_if;
  logic                                valid;
  logic                                ready;
  logic [gnorm_pkg::ROW_W-1:0]         row_number;
  logic signed [gnorm_pkg::NBR_W-1:0]  neighbor_number;
  logic [gnorm_pkg::DIST_W-1:0]        neighbor_distance;
  logic                                row_end;
  modport source (output valid, row_number, neighbor_number, neighbor_distance, row_end,
                  input ready);
  modport sink (input valid, row_number, neighbor_number, neighbor_distance, row_end,
                output ready);
endinterface

interface gnorm_out_if;
  logic                         valid;
  logic                         ready;
  logic [gnorm_pkg::ROW_W-1:0]  out_row;
  logic [gnorm_pkg::COL_W-1:0]  out_column;
  logic [gnorm_pkg::WGT_W-1:0]  out_weight;
  logic                         last_of_row;
  logic [gnorm_pkg::EDGE_W-1:0] edges_so_far;
  logic [gnorm_pkg::TOT_W-1:0]  weight_total;
  modport source (output valid, out_row, out_column, out_weight, last_of_row,
                  edges_so_far, weight_total, input ready);
  modport sink (input valid, out_row, out_column, out_weight, last_of_row,
                edges_so_far, weight_total, output ready);
endinterface

interface gnorm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gnorm_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/neighbor_gaussian_row_normalizer_top.sv -----
// top level: config registers, front end, candidate queue and back end
// depends on gnorm_pkg, gnorm_channels, gnorm_front, gnorm_queue, gnorm_back
// flow: a dropped or self candidate goes straight to the store state, a gaussian one first
// runs the ten-term series on the shared 33x33 multiplier
// row end: each kept entry goes through the 57-step divider with normalization, straight to output without
// throughput: one candidate at a time in the back end; the queue holds two more
// reset: synchronous active low, clears counters and row state, loads register defaults
`default_nettype none
module neighbor_gaussian_row_normalizer_top #(
  parameter int unsigned MAX_NEIGHBORS = gnorm_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gnorm_in_if.sink     in_if,
  gnorm_out_if.source  out_if,
  gnorm_cfg_if.sink    cfg_if
);

  gnorm_pkg::cfg_t  cfg_r;
  gnorm_pkg::cand_t push_data, pop_data;
  logic             push, full, pop, avail;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exp_coef     <= 32'h0100_0000;
      cfg_r.radius_limit <= 32'hFFFF_FFFF;
      cfg_r.radius_en    <= 1'b0;
      cfg_r.normalize    <= 1'b1;
      cfg_r.self_link_w  <= 32'd0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        gnorm_pkg::CFG_EXP_COEF:     cfg_r.exp_coef     <= cfg_if.data;
        gnorm_pkg::CFG_RADIUS_LIMIT: cfg_r.radius_limit <= cfg_if.data;
        gnorm_pkg::CFG_RADIUS_EN:    cfg_r.radius_en    <= cfg_if.data[0];
        gnorm_pkg::CFG_NORMALIZE:    cfg_r.normalize    <= cfg_if.data[0];
        gnorm_pkg::CFG_SELF_WEIGHT:  cfg_r.self_link_w  <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  gnorm_front u_front (
    .in_if  (in_if),
    .cfg    (cfg_r),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  gnorm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  gnorm_back #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_avail (avail),
    .q_data  (pop_data),
    .q_pop   (pop),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/gnorm_front.sv -----
// front end: accepts candidate words and classifies them for the back end
// depends on gnorm_pkg and gnorm_channels
`default_nettype none
module gnorm_front (
  gnorm_in_if.sink          in_if,
  input  gnorm_pkg::cfg_t   cfg,
  input  logic              q_full,
  output logic              q_push,
  output gnorm_pkg::cand_t  q_data
);

  logic                          positive;
  logic [gnorm_pkg::NBR_W-1:0]   col_w;
  logic                          col_ok;
  gnorm_pkg::cand_kind_t         kind;

  // handshake into the queue
  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  // zero-based column and range check
  assign positive = !in_if.neighbor_number[gnorm_pkg::NBR_W-1] &&
                    (in_if.neighbor_number != '0);
  assign col_w    = gnorm_pkg::NBR_W'(in_if.neighbor_number) - gnorm_pkg::NBR_W'(1);
  assign col_ok   = (col_w >> gnorm_pkg::INDEX_BITS) == '0;

  // candidate classification, order decides
  always_comb begin
    priority if (!positive || !col_ok) begin
      kind = gnorm_pkg::KIND_DROP;
    end else if (cfg.radius_en && (in_if.neighbor_distance > cfg.radius_limit)) begin
      kind = gnorm_pkg::KIND_DROP;
    end else if (col_w == gnorm_pkg::NBR_W'(in_if.row_number)) begin
      kind = (cfg.self_link_w != '0) ? gnorm_pkg::KIND_SELF : gnorm_pkg::KIND_DROP;
    end else if (in_if.neighbor_distance == '0) begin
      kind = gnorm_pkg::KIND_DROP;
    end else begin
      kind = gnorm_pkg::KIND_GAUSS;
    end
  end

  assign q_data.row      = in_if.row_number;
  assign q_data.col      = col_w[gnorm_pkg::COL_W-1:0];
  assign q_data.distance = in_if.neighbor_distance;
  assign q_data.kind     = kind;
  assign q_data.row_end  = in_if.row_end;

endmodule
`default_nettype wire

// ----- hw/rtl/gnorm_queue.sv -----
// short queue of classified candidates between front and back end
// depends on gnorm_pkg
`default_nettype none
module gnorm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gnorm_pkg::cand_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output gnorm_pkg::cand_t pop_data
);

  localparam int unsigned PTR_W = (gnorm_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(gnorm_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(gnorm_pkg::QUEUE_DEPTH + 1);

  gnorm_pkg::cand_t  slot_r [gnorm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = cnt_r == CNT_W'(gnorm_pkg::QUEUE_DEPTH);
  assign avail    = cnt_r != '0;
  assign pop_data = slot_r[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(gnorm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(gnorm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gnorm_back.sv -----
// back end: gaussian weight sequencer, row buffer, row sum divider, output register
// depends on gnorm_pkg, gnorm_channels and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module gnorm_back #(
  parameter int unsigned MAX_NEIGHBORS = gnorm_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gnorm_pkg::cfg_t  cfg,
  input  logic             q_avail,
  input  gnorm_pkg::cand_t q_data,
  output logic             q_pop,
  gnorm_out_if.source      out_if
);

  localparam int unsigned KEPT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned IDX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned ACC_W  = gnorm_pkg::WGT_W + KEPT_W;
  localparam int unsigned DCNT_W = $clog2(gnorm_pkg::DIV_W + 1);

  gnorm_pkg::back_state_t state_r, state_nxt;
  gnorm_pkg::cand_t       cur_r;

  logic [32:0]   mul_a, mul_b;
  logic [65:0]   prod_r;
  logic [28:0]   xhi_r;
  logic [31:0]   lo_r;
  logic [32:0]   x_r;
  logic [5:0]    m_r;
  logic [31:0]   t_r;
  logic [32:0]   r_r;
  logic [31:0]   q_r;
  logic [3:0]    k_r;
  logic [31:0]   w_r;

  logic [gnorm_pkg::COL_W-1:0] col_buf_r [MAX_NEIGHBORS];
  logic [gnorm_pkg::WGT_W-1:0] wgt_buf_r [MAX_NEIGHBORS];
  logic [KEPT_W-1:0]           kept_r;
  logic [ACC_W-1:0]            acc_r;
  logic [IDX_W-1:0]            idx_r;

  logic [gnorm_pkg::DIV_W-1:0] num_r;
  logic [ACC_W-1:0]            rem_r;
  logic [DCNT_W-1:0]           dcnt_r;
  logic [31:0]                 res_r;

  logic                          out_v_r;
  logic [gnorm_pkg::ROW_W-1:0]   o_row_r;
  logic [gnorm_pkg::COL_W-1:0]   o_col_r;
  logic [gnorm_pkg::WGT_W-1:0]   o_w_r;
  logic                          o_last_r;
  logic [gnorm_pkg::EDGE_W-1:0]  edge_r;
  logic [gnorm_pkg::TOT_W-1:0]   total_r;

  // combinational helpers
  logic        lo_over, xc_over, store_ok, emit_fire, is_last, use_div, rem_ge;
  logic [31:0] qe, quo, rem_k;
  logic [6:0]  shift_s;
  logic [39:0] round_sum;
  logic [ACC_W:0] rem_sh;
  logic [gnorm_pkg::TOT_W:0] tot_sum;

  assign lo_over   = prod_r[63:0] >= 64'(gnorm_pkg::X_CAP);
  assign xc_over   = x_r >= 33'(gnorm_pkg::X_CAP);
  assign qe        = prod_r[63:32];
  assign rem_k     = q_r - 32'(qe * 32'(k_r));
  assign quo       = qe + ((rem_k >= 32'(k_r)) ? 32'd1 : 32'd0);
  assign shift_s   = 7'd8 + 7'(m_r);
  assign round_sum = 40'(r_r) + (40'd1 << (shift_s - 7'd1));
  assign store_ok  = (w_r != '0) && (kept_r < KEPT_W'(MAX_NEIGHBORS));
  assign emit_fire = (state_r == gnorm_pkg::ST_EMIT) && (!out_v_r || out_if.ready);
  assign is_last   = (KEPT_W'(idx_r) + KEPT_W'(1)) == kept_r;
  assign use_div   = cfg.normalize && (acc_r != '0);
  assign rem_sh    = {rem_r, num_r[gnorm_pkg::DIV_W-1]};
  assign rem_ge    = rem_sh >= (ACC_W+1)'(acc_r);
  assign tot_sum   = (gnorm_pkg::TOT_W+1)'(total_r) + (gnorm_pkg::TOT_W+1)'(res_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gnorm_pkg::ST_IDLE: begin
        if (q_avail) begin
          state_nxt = (q_data.kind == gnorm_pkg::KIND_GAUSS) ? gnorm_pkg::ST_D2
                                                             : gnorm_pkg::ST_STORE;
        end
      end
      gnorm_pkg::ST_D2:    state_nxt = gnorm_pkg::ST_HI;
      gnorm_pkg::ST_HI:    state_nxt = gnorm_pkg::ST_LO;
      gnorm_pkg::ST_LO:    state_nxt = lo_over ? gnorm_pkg::ST_STORE : gnorm_pkg::ST_X;
      gnorm_pkg::ST_X:     state_nxt = gnorm_pkg::ST_XC;
      gnorm_pkg::ST_XC:    state_nxt = xc_over ? gnorm_pkg::ST_STORE : gnorm_pkg::ST_Y;
      gnorm_pkg::ST_Y:     state_nxt = gnorm_pkg::ST_T;
      gnorm_pkg::ST_T:     state_nxt = gnorm_pkg::ST_MUL;
      gnorm_pkg::ST_MUL:   state_nxt = gnorm_pkg::ST_QUO;
      gnorm_pkg::ST_QUO:   state_nxt = gnorm_pkg::ST_FIX;
      gnorm_pkg::ST_FIX:   state_nxt = (k_r == 4'd1) ? gnorm_pkg::ST_ROUND : gnorm_pkg::ST_MUL;
      gnorm_pkg::ST_ROUND: state_nxt = gnorm_pkg::ST_STORE;
      gnorm_pkg::ST_STORE: state_nxt = cur_r.row_end ? gnorm_pkg::ST_ENDCHK
                                                     : gnorm_pkg::ST_IDLE;
      gnorm_pkg::ST_ENDCHK: state_nxt = (kept_r == '0) ? gnorm_pkg::ST_IDLE
                                                       : gnorm_pkg::ST_LOAD;
      gnorm_pkg::ST_LOAD:  state_nxt = use_div ? gnorm_pkg::ST_DIV : gnorm_pkg::ST_EMIT;
      gnorm_pkg::ST_DIV:   state_nxt = (dcnt_r == DCNT_W'(1)) ? gnorm_pkg::ST_SAT
                                                              : gnorm_pkg::ST_DIV;
      gnorm_pkg::ST_SAT:   state_nxt = gnorm_pkg::ST_EMIT;
      gnorm_pkg::ST_EMIT: begin
        if (emit_fire) begin
          state_nxt = is_last ? gnorm_pkg::ST_IDLE : gnorm_pkg::ST_LOAD;
        end
      end
      default: state_nxt = gnorm_pkg::ST_IDLE;
    endcase
  end

  // control outputs: queue pop and shared multiplier operands
  always_comb begin
    q_pop = (state_r == gnorm_pkg::ST_IDLE) && q_avail;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      gnorm_pkg::ST_D2: begin
        mul_a = 33'(cur_r.distance);
        mul_b = 33'(cur_r.distance);
      end
      gnorm_pkg::ST_HI: begin
        mul_a = 33'(prod_r[63:32]);
        mul_b = 33'(cfg.exp_coef);
      end
      gnorm_pkg::ST_LO: begin
        mul_a = 33'(lo_r);
        mul_b = 33'(cfg.exp_coef);
      end
      gnorm_pkg::ST_XC: begin
        mul_a = 33'(x_r[28:0]);
        mul_b = gnorm_pkg::LOG2E_Q32;
      end
      gnorm_pkg::ST_Y: begin
        mul_a = 33'(prod_r[55:32]);
        mul_b = 33'(gnorm_pkg::LN2_Q32);
      end
      gnorm_pkg::ST_MUL: begin
        mul_a = 33'(t_r);
        mul_b = r_r;
      end
      gnorm_pkg::ST_QUO: begin
        mul_a = 33'(prod_r[63:32]);
        mul_b = 33'(gnorm_pkg::recip_k(k_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gnorm_pkg::ST_IDLE;
      kept_r  <= '0;
      acc_r   <= '0;
      edge_r  <= '0;
      total_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gnorm_pkg::ST_STORE && store_ok) begin
        kept_r <= kept_r + KEPT_W'(1);
        acc_r  <= acc_r + ACC_W'(w_r);
      end
      if (emit_fire) begin
        out_v_r <= 1'b1;
        if (edge_r != '1) begin
          edge_r <= edge_r + gnorm_pkg::EDGE_W'(1);
        end
        total_r <= tot_sum[gnorm_pkg::TOT_W] ? '1 : tot_sum[gnorm_pkg::TOT_W-1:0];
        if (is_last) begin
          kept_r <= '0;
          acc_r  <= '0;
        end
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (q_pop) begin
      cur_r <= q_data;
      w_r   <= (q_data.kind == gnorm_pkg::KIND_SELF) ? cfg.self_link_w : 32'd0;
    end
    unique case (state_r)
      gnorm_pkg::ST_HI: lo_r <= prod_r[31:0];
      gnorm_pkg::ST_LO: begin
        xhi_r <= prod_r[28:0];
        if (lo_over) begin
          w_r <= '0;
        end
      end
      gnorm_pkg::ST_X:  x_r <= 33'(xhi_r) + 33'(prod_r[63:32]);
      gnorm_pkg::ST_XC: begin
        if (xc_over) begin
          w_r <= '0;
        end
      end
      gnorm_pkg::ST_Y:  m_r <= prod_r[61:56];
      gnorm_pkg::ST_T: begin
        t_r <= prod_r[55:24];
        r_r <= gnorm_pkg::ONE_Q32;
        k_r <= gnorm_pkg::TAYLOR_K;
      end
      gnorm_pkg::ST_QUO: q_r <= prod_r[63:32];
      gnorm_pkg::ST_FIX: begin
        r_r <= gnorm_pkg::ONE_Q32 - 33'(quo);
        k_r <= k_r - 4'd1;
      end
      gnorm_pkg::ST_ROUND: w_r <= (shift_s >= 7'd40) ? 32'd0 : 32'(round_sum >> shift_s);
      gnorm_pkg::ST_ENDCHK: idx_r <= '0;
      gnorm_pkg::ST_LOAD: begin
        num_r  <= gnorm_pkg::DIV_W'({wgt_buf_r[idx_r], 24'd0}) +
                  gnorm_pkg::DIV_W'(acc_r >> 1);
        rem_r  <= '0;
        dcnt_r <= DCNT_W'(gnorm_pkg::DIV_W);
        res_r  <= wgt_buf_r[idx_r];
      end
      gnorm_pkg::ST_DIV: begin
        rem_r  <= rem_ge ? ACC_W'(rem_sh - (ACC_W+1)'(acc_r)) : rem_sh[ACC_W-1:0];
        num_r  <= {num_r[gnorm_pkg::DIV_W-2:0], rem_ge};
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      gnorm_pkg::ST_SAT: res_r <= (num_r[gnorm_pkg::DIV_W-1:32] != '0) ? '1 : num_r[31:0];
      gnorm_pkg::ST_EMIT: begin
        if (emit_fire) begin
          o_row_r  <= cur_r.row;
          o_col_r  <= col_buf_r[idx_r];
          o_w_r    <= res_r;
          o_last_r <= is_last;
          idx_r    <= idx_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // row buffer writes
  always_ff @(posedge clk) begin
    if (state_r == gnorm_pkg::ST_STORE && store_ok) begin
      col_buf_r[kept_r[IDX_W-1:0]] <= cur_r.col;
      wgt_buf_r[kept_r[IDX_W-1:0]] <= w_r;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.out_row      = o_row_r;
  assign out_if.out_column   = o_col_r;
  assign out_if.out_weight   = o_w_r;
  assign out_if.last_of_row  = o_last_r;
  assign out_if.edges_so_far = edge_r;
  assign out_if.weight_total = total_r;

  // checks
  `GN_CHECK(a_kept_bound, kept_r <= KEPT_W'(MAX_NEIGHBORS), "row buffer count overflow")
  `GN_CHECK(a_emit_idx, (state_r != gnorm_pkg::ST_EMIT) || (KEPT_W'(idx_r) < kept_r), "emit past buffer")
  `GN_CHECK_NEXT(a_series_end, (state_r == gnorm_pkg::ST_FIX) && (k_r == 4'd1), state_r == gnorm_pkg::ST_ROUND, "series did not finish")

endmodule
`default_nettype wire
